@@ hdl/mbrhm_pkg.sv @@
// ----------------------------------------------------------------------------
// mbrhm_pkg
// Shared types, codes and the CRC-16 byte step for the Modbus read master.
// ----------------------------------------------------------------------------
package mbrhm_pkg;

	// Kinds of input items.
	typedef enum logic [1:0] {
		KIND_REQUEST = 2'd0,
		KIND_BYTE    = 2'd1,
		KIND_TICK    = 2'd2
	} item_kind_t;

	// Kinds of result items.
	typedef enum logic [1:0] {
		RES_TX_BYTE = 2'd0,
		RES_REGISTER = 2'd1,
		RES_STATUS  = 2'd2
	} result_kind_t;

	// Transaction status codes.
	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_BAD_FUNC = 3'd1,
		STAT_BAD_LEN  = 3'd2,
		STAT_BAD_CRC  = 3'd3,
		STAT_TIMEOUT  = 3'd4
	} status_code_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SLAVE_ID   = 2'd0;
	localparam logic [1:0] CFG_START_REG  = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT    = 2'd2;

	localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
	localparam logic [15:0] CRC_INIT        = 16'hFFFF;
	localparam logic [15:0] CRC_POLY        = 16'hA001;
	localparam logic [7:0]  SLAVE_ID_RESET  = 8'd1;
	localparam logic [15:0] START_REG_RESET = 16'd0;
	localparam logic [15:0] TIMEOUT_RESET   = 16'd500;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic tx_beat;
		logic check;
		logic rd_en;
		logic hi_cap;
		logic reg_beat;
		logic stat_beat;
	} mbrhm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic ev_request;
		logic ev_reply_done;
		logic ev_timeout;
		logic check_err;
		logic tx_last;
		logic reg_last;
		logic out_free;
	} mbrhm_stat_t;

	// One result beat as held in the output register.
	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  tx_byte;
		logic [5:0]  reg_index;
		logic [15:0] reg_value;
		logic [2:0]  status;
		logic [31:0] error_total;
		logic [31:0] good_total;
		logic        last;
	} mbrhm_result_t;

	// CRC-16 update by one byte, reflected polynomial, LSB first.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
		input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ hdl/mbrhm_item_if.sv @@
// ----------------------------------------------------------------------------
// mbrhm_item_if
// Input channel: valid/ready handshake carrying one input item per beat.
// ----------------------------------------------------------------------------
interface mbrhm_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] rx_byte;

	modport source (output valid, output kind, output rx_byte, input ready);
	modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

@@ hdl/mbrhm_result_if.sv @@
// ----------------------------------------------------------------------------
// mbrhm_result_if
// Output channel: valid/ready handshake carrying one result item per beat.
// ----------------------------------------------------------------------------
interface mbrhm_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [7:0]  tx_byte;
	logic [5:0]  reg_index;
	logic [15:0] reg_value;
	logic [2:0]  status;
	logic [31:0] error_total;
	logic [31:0] good_total;
	logic        last;

	modport source (output valid, output result_kind, output tx_byte,
		output reg_index, output reg_value, output status, output error_total,
		output good_total, output last, input ready);
	modport sink (input valid, input result_kind, input tx_byte,
		input reg_index, input reg_value, input status, input error_total,
		input good_total, input last, output ready);
endinterface

@@ hdl/mbrhm_ram.sv @@
// ----------------------------------------------------------------------------
// mbrhm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mbrhm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 37
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

@@ hdl/mbrhm_datapath.sv @@
// ----------------------------------------------------------------------------
// mbrhm_datapath
// Configuration, reply store, CRC unit, counters and the result register.
// ----------------------------------------------------------------------------
module mbrhm_datapath
	import mbrhm_pkg::*;
#(
	parameter int NUM_REGS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [15:0]            cfg_data,
	input  logic [1:0]             item_kind,
	input  logic [7:0]             item_rx_byte,
	input  mbrhm_cmd_t             cmd,
	output mbrhm_stat_t            stat,
	mbrhm_result_if.source         result
);
	localparam int REPLY_BYTES = 5 + 2 * NUM_REGS;
	localparam int AW          = $clog2(REPLY_BYTES);
	localparam logic [7:0] BYTE_COUNT = 8'(2 * NUM_REGS);
	localparam logic [7:0] NUM_REGS_HI = 8'(NUM_REGS >> 8);
	localparam logic [7:0] NUM_REGS_LO = 8'(NUM_REGS);

	logic [7:0]    slave_id_q;
	logic [15:0]   start_reg_q;
	logic [15:0]   timeout_q;
	logic          waiting_q;
	logic [AW-1:0] len_q;
	logic [15:0]   elapsed_q;
	logic [31:0]   error_q;
	logic [31:0]   frame_q;
	logic [2:0]    tx_idx_q;
	logic [AW-1:0] rd_addr_q;
	logic [5:0]    reg_idx_q;
	status_code_t  status_q;
	logic          out_valid_q;

	logic [15:0]   crc_q;
	logic [7:0]    b0_q;
	logic          bad_fn_q;
	logic          bad_cnt_q;
	logic [15:0]   got_q;
	logic [7:0]    hi_q;
	mbrhm_result_t out_q;

	logic          is_byte;
	logic          is_tick;
	logic          ram_we;
	logic [7:0]    rdata;
	logic [7:0]    tx_mux;
	status_code_t  check_code;
	logic          out_load;
	mbrhm_result_t out_d;

	assign is_byte = cmd.accept && (item_kind == KIND_BYTE) && waiting_q;
	assign is_tick = cmd.accept && (item_kind == KIND_TICK) && waiting_q;
	assign ram_we  = is_byte;

	mbrhm_ram #(
		.WIDTH(8),
		.DEPTH(REPLY_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (len_q),
		.wdata (item_rx_byte),
		.re    (cmd.rd_en),
		.raddr (rd_addr_q),
		.rdata (rdata)
	);

	always_comb begin
		unique case (tx_idx_q)
			3'd0: tx_mux = slave_id_q;
			3'd1: tx_mux = FN_READ_HOLDING;
			3'd2: tx_mux = start_reg_q[15:8];
			3'd3: tx_mux = start_reg_q[7:0];
			3'd4: tx_mux = NUM_REGS_HI;
			3'd5: tx_mux = NUM_REGS_LO;
			3'd6: tx_mux = crc_q[7:0];
			default: tx_mux = crc_q[15:8];
		endcase
	end

	// Checks run in the order address/function, byte count, CRC.
	always_comb begin
		priority if (b0_q != slave_id_q || bad_fn_q) begin
			check_code = STAT_BAD_FUNC;
		end else if (bad_cnt_q) begin
			check_code = STAT_BAD_LEN;
		end else if (crc_q != got_q) begin
			check_code = STAT_BAD_CRC;
		end else begin
			check_code = STAT_OK;
		end
	end

	assign stat.ev_request    = item_kind == KIND_REQUEST;
	assign stat.ev_reply_done = (item_kind == KIND_BYTE) && waiting_q &&
		(len_q == AW'(REPLY_BYTES - 1));
	assign stat.ev_timeout    = (item_kind == KIND_TICK) && waiting_q &&
		(elapsed_q >= timeout_q);
	assign stat.check_err     = check_code != STAT_OK;
	assign stat.tx_last       = tx_idx_q == 3'd7;
	assign stat.reg_last      = reg_idx_q == 6'(NUM_REGS - 1);
	assign stat.out_free      = !out_valid_q || result.ready;

	assign out_load = cmd.tx_beat || cmd.reg_beat || cmd.stat_beat;

	always_comb begin
		out_d = '0;
		if (cmd.tx_beat) begin
			out_d.result_kind = RES_TX_BYTE;
			out_d.tx_byte     = tx_mux;
			out_d.last        = tx_idx_q == 3'd7;
		end else if (cmd.reg_beat) begin
			out_d.result_kind = RES_REGISTER;
			out_d.reg_index   = reg_idx_q;
			out_d.reg_value   = {hi_q, rdata};
		end else begin
			out_d.result_kind = RES_STATUS;
			out_d.status      = status_q;
			out_d.error_total = error_q;
			out_d.good_total  = frame_q;
			out_d.last        = 1'b1;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_id_q  <= SLAVE_ID_RESET;
			start_reg_q <= START_REG_RESET;
			timeout_q   <= TIMEOUT_RESET;
			waiting_q   <= 1'b0;
			len_q       <= '0;
			elapsed_q   <= '0;
			error_q     <= '0;
			frame_q     <= '0;
			tx_idx_q    <= '0;
			rd_addr_q   <= '0;
			reg_idx_q   <= '0;
			status_q    <= STAT_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SLAVE_ID:  slave_id_q  <= cfg_data[7:0];
					CFG_START_REG: start_reg_q <= cfg_data;
					CFG_TIMEOUT:   timeout_q   <= cfg_data;
					default: ;
				endcase
			end

			if (cmd.accept && item_kind == KIND_REQUEST) begin
				waiting_q <= 1'b1;
				len_q     <= '0;
				elapsed_q <= '0;
				tx_idx_q  <= '0;
			end else if (is_byte) begin
				len_q <= len_q + AW'(1);
				if (len_q == AW'(REPLY_BYTES - 1)) begin
					waiting_q <= 1'b0;
				end
			end else if (is_tick) begin
				if (elapsed_q >= timeout_q) begin
					waiting_q <= 1'b0;
					error_q   <= error_q + 32'd1;
					status_q  <= STAT_TIMEOUT;
				end else begin
					elapsed_q <= elapsed_q + 16'd1;
				end
			end

			if (cmd.tx_beat) begin
				tx_idx_q <= tx_idx_q + 3'd1;
			end

			if (cmd.check) begin
				status_q  <= check_code;
				rd_addr_q <= AW'(3);
				reg_idx_q <= '0;
				if (check_code != STAT_OK) begin
					error_q <= error_q + 32'd1;
				end else begin
					frame_q <= frame_q + 32'd1;
				end
			end

			if (cmd.rd_en) begin
				rd_addr_q <= rd_addr_q + AW'(1);
			end
			if (cmd.reg_beat) begin
				reg_idx_q <= reg_idx_q + 6'd1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.accept && item_kind == KIND_REQUEST) begin
			crc_q <= CRC_INIT;
		end else if (is_byte) begin
			if (len_q < AW'(REPLY_BYTES - 2)) begin
				crc_q <= crc_byte(crc_q, item_rx_byte);
			end
			if (len_q == AW'(0)) begin
				b0_q <= item_rx_byte;
			end
			if (len_q == AW'(1)) begin
				bad_fn_q <= item_rx_byte != FN_READ_HOLDING;
			end
			if (len_q == AW'(2)) begin
				bad_cnt_q <= item_rx_byte != BYTE_COUNT;
			end
			if (len_q == AW'(REPLY_BYTES - 2)) begin
				got_q[7:0] <= item_rx_byte;
			end
			if (len_q == AW'(REPLY_BYTES - 1)) begin
				got_q[15:8] <= item_rx_byte;
			end
		end else if (cmd.tx_beat) begin
			// The request CRC covers the first six frame bytes; after the
			// last frame byte the register restarts for the reply.
			if (tx_idx_q < 3'd6) begin
				crc_q <= crc_byte(crc_q, tx_mux);
			end else if (tx_idx_q == 3'd7) begin
				crc_q <= CRC_INIT;
			end
		end

		if (cmd.hi_cap) begin
			hi_q <= rdata;
		end

		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.result_kind = out_q.result_kind;
	assign result.tx_byte     = out_q.tx_byte;
	assign result.reg_index   = out_q.reg_index;
	assign result.reg_value   = out_q.reg_value;
	assign result.status      = out_q.status;
	assign result.error_total = out_q.error_total;
	assign result.good_total  = out_q.good_total;
	assign result.last        = out_q.last;
endmodule

@@ hdl/mbrhm_ctrl.sv @@
// ----------------------------------------------------------------------------
// mbrhm_ctrl
// Transaction sequencer: frame transmit, reply check and register readout.
// ----------------------------------------------------------------------------
module mbrhm_ctrl
	import mbrhm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  mbrhm_stat_t stat,
	output mbrhm_cmd_t  cmd
);
	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_TX      = 7'b0000010,
		ST_CHECK   = 7'b0000100,
		ST_RD_HI   = 7'b0001000,
		ST_RD_LO   = 7'b0010000,
		ST_REG_OUT = 7'b0100000,
		ST_STATUS  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign item_ready = state_q == ST_IDLE;
	assign accept     = item_valid && item_ready;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.accept    = accept;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (stat.ev_request) begin
						state_d = ST_TX;
					end else if (stat.ev_reply_done) begin
						state_d = ST_CHECK;
					end else if (stat.ev_timeout) begin
						state_d = ST_STATUS;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_TX: begin
				if (stat.out_free) begin
					cmd.tx_beat = 1'b1;
					if (stat.tx_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = stat.check_err ? ST_STATUS : ST_RD_HI;
			end
			ST_RD_HI: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_RD_LO;
			end
			ST_RD_LO: begin
				// The high byte arrives while the low byte is being read.
				cmd.rd_en  = 1'b1;
				cmd.hi_cap = 1'b1;
				state_d    = ST_REG_OUT;
			end
			ST_REG_OUT: begin
				if (stat.out_free) begin
					cmd.reg_beat = 1'b1;
					state_d      = stat.reg_last ? ST_STATUS : ST_RD_HI;
				end
			end
			ST_STATUS: begin
				if (stat.out_free) begin
					cmd.stat_beat = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

@@ hdl/modbus_read_holding_master_top.sv @@
// ----------------------------------------------------------------------------
// modbus_read_holding_master_top
// Modbus RTU master for one read-holding-registers transaction.
// ----------------------------------------------------------------------------
// A request item produces the eight request frame bytes, one beat per cycle
// while the result sink is ready. The byte that completes the reply leads to
// a check, then for each register two reads of the single reply-store read
// port and one result beat, and at the end one status beat. A failed reply
// gives a single status beat after the check; a timeout gives one too. One
// item is handled at a time; a new item is taken while the last result beat
// still waits in the output register. The reply store needs no clearing
// after reset. Configuration is written through cfg_we, cfg_index and
// cfg_data; writes to unused indexes are ignored.
module modbus_read_holding_master_top
	import mbrhm_pkg::*;
#(
	parameter int NUM_REGS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	mbrhm_item_if.sink     item,
	mbrhm_result_if.source result
);
	mbrhm_cmd_t  cmd;
	mbrhm_stat_t stat;
	logic        item_ready;

	assign item.ready = item_ready;

	mbrhm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	mbrhm_datapath #(
		.NUM_REGS(NUM_REGS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_kind    (item.kind),
		.item_rx_byte (item.rx_byte),
		.cmd          (cmd),
		.stat         (stat),
		.result       (result)
	);
endmodule
